// File: src/pli_pkg.sv
// ----------------------------------------------------------------------------
// pli_pkg
// Shared types and constants for the piecewise linear interpolator.
// ----------------------------------------------------------------------------
package pli_pkg;

  // field widths
  localparam int DEPTH_W = 24;
  localparam int TIME_W  = 24;
  localparam int IDX_W   = 5;
  localparam int NUMP_W  = 5;
  localparam int STAT_W  = 2;

  // arithmetic widths: signed differences, exact product, divider operands
  localparam int DIFF_W    = DEPTH_W + 1;
  localparam int PROD_W    = 2 * DEPTH_W + 1;
  localparam int DIV_W     = 2 * DEPTH_W;
  localparam int DEN_W     = DEPTH_W;
  localparam int DIV_STEPS = DIV_W;
  localparam int SUM_W     = PROD_W + 1;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  // operation codes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // result status codes
  localparam logic [STAT_W-1:0] RSTAT_WITHIN     = 2'd0;
  localparam logic [STAT_W-1:0] RSTAT_EXTRAP     = 2'd1;
  localparam logic [STAT_W-1:0] RSTAT_ZERO_WIDTH = 2'd2;

  typedef struct packed {
    logic               operation;
    logic [IDX_W-1:0]   point_index;
    logic [DEPTH_W-1:0] depth_value;
    logic [TIME_W-1:0]  time_value;
  } pli_in_t;

  typedef struct packed {
    logic [TIME_W-1:0] result_time;
    logic [STAT_W-1:0] result_status;
  } pli_out_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_LO_RD,
    S_HI_RD,
    S_HI_WT,
    S_MUL,
    S_DIV_GO,
    S_DIV_WAIT,
    S_FIX,
    S_DONE
  } pli_state_t;

  // which breakpoint the table read port fetches
  typedef enum logic [1:0] {
    RD_NONE,
    RD_SRCH,
    RD_LO,
    RD_HI
  } pli_rd_t;

  typedef struct packed {
    logic    acc_wr;
    logic    acc_q;
    logic    k_inc;
    logic    seg_found;
    logic    seg_last;
    pli_rd_t rd_sel;
    logic    cap_lo;
    logic    cap_hi;
    logic    mul;
    logic    div_start;
    logic    fix;
    logic    load_out;
  } pli_cmd_t;

  typedef struct packed {
    logic k_lt_n;
    logic gt;
    logic zero_width;
    logic div_done;
  } pli_stat_t;

endpackage

// File: src/pli_stream_if.sv
// ----------------------------------------------------------------------------
// pli_stream_if
// Valid/ready channel carrying one payload per transfer.
// ----------------------------------------------------------------------------
interface pli_stream_if #(
  parameter type DATA_T = logic
) ();
  logic  valid;
  logic  ready;
  DATA_T data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: src/pli_div.sv
// ----------------------------------------------------------------------------
// pli_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pli_div import pli_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  output logic             done,
  output logic [DIV_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DIV_STEPS);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DIV_W-1:0] quo_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [DIV_W-1:0] quo_nxt;
  logic [DEN_W-1:0] rem_nxt;
  logic [DEN_W:0]   sh;
  logic [DEN_W:0]   diff;
  logic             ge;

  // one trial subtraction
  always_comb begin
    sh      = {rem_r, quo_r[DIV_W-1]};
    ge      = (sh >= {1'b0, den_r});
    diff    = sh - {1'b0, den_r};
    rem_nxt = ge ? diff[DEN_W-1:0] : sh[DEN_W-1:0];
    quo_nxt = {quo_r[DIV_W-2:0], ge};
  end

  // step counter and done pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // shift registers
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      den_r <= divisor;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// File: src/pli_datapath.sv
// ----------------------------------------------------------------------------
// pli_datapath
// Breakpoint table, segment search registers, multiply, divide and saturate.
// ----------------------------------------------------------------------------
module pli_datapath import pli_pkg::*; #(
  parameter int MAX_POINTS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  pli_in_t           in_data,
  input  logic              cfg_we,
  input  logic [NUMP_W-1:0] cfg_data,
  input  pli_cmd_t          cmd,
  output pli_stat_t         stat,
  output pli_out_t          out_data
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int IW = $clog2(MAX_POINTS + 1);
  localparam int CW = (IW > IDX_W) ? IW : IDX_W;
  localparam int WORD_W = DEPTH_W + TIME_W;

  // table storage: one word per breakpoint, depth above time
  logic [WORD_W-1:0]     mem [MAX_POINTS];
  logic [MAX_POINTS-1:0] valid_r;

  logic [NUMP_W-1:0]  num_points_r;
  logic [DEPTH_W-1:0] q_r;
  logic [IW-1:0]      k_r;
  logic [IW-1:0]      seg_r;
  logic               found_r;
  logic [WORD_W-1:0]  rd_word_r;
  logic               rd_zero_r;
  logic [DEPTH_W-1:0] d0_r, d1_r;
  logic [TIME_W-1:0]  t0_r, t1_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [DIFF_W-1:0] den_r;
  logic               neg_r;
  logic signed [PROD_W-1:0] quot_r;
  pli_out_t           out_r;

  logic [CW-1:0]      np_ext;
  logic [CW-1:0]      n_clamp;
  logic [IW-1:0]      n_eff;
  logic [CW-1:0]      idx_ext;
  logic [CW-1:0]      wr_pt;
  logic               wr_ok;
  logic [AW-1:0]      wr_addr;
  logic [IW-1:0]      rd_pt;
  logic [IW-1:0]      rd_pt_m1;
  logic               rd_en;
  logic               rd_is_origin;
  logic [AW-1:0]      rd_addr;
  logic [DEPTH_W-1:0] rd_depth;
  logic [TIME_W-1:0]  rd_time;
  logic signed [DIFF_W-1:0] dq, dt, dd;
  logic signed [PROD_W-1:0] prod_mag;
  logic signed [DIFF_W-1:0] den_mag;
  logic [DIV_W-1:0]   div_quo;
  logic               div_done;
  logic signed [SUM_W-1:0] sum;
  logic [TIME_W-1:0]  sat_time;
  logic               zero_width;
  logic [STAT_W-1:0]  status;

  // effective breakpoint count, clamped to 1..MAX_POINTS
  always_comb begin
    np_ext = CW'(num_points_r);
    if (np_ext == '0) begin
      n_clamp = CW'(1);
    end else if (np_ext > CW'(MAX_POINTS)) begin
      n_clamp = CW'(MAX_POINTS);
    end else begin
      n_clamp = np_ext;
    end
    n_eff = n_clamp[IW-1:0];
  end

  // write slot decode, slots outside 1..MAX_POINTS are dropped
  always_comb begin
    idx_ext = CW'(in_data.point_index);
    wr_pt   = idx_ext - CW'(1);
    wr_ok   = (idx_ext != '0) && (idx_ext <= CW'(MAX_POINTS));
    wr_addr = wr_pt[AW-1:0];
  end

  // read point select, point 0 is the fixed origin
  always_comb begin
    case (cmd.rd_sel)
      RD_SRCH: rd_pt = k_r;
      RD_LO:   rd_pt = seg_r;
      RD_HI:   rd_pt = seg_r + IW'(1);
      default: rd_pt = '0;
    endcase
    rd_en        = (cmd.rd_sel != RD_NONE);
    rd_is_origin = (rd_pt == '0);
    rd_pt_m1     = rd_pt - IW'(1);
    rd_addr      = rd_is_origin ? '0 : rd_pt_m1[AW-1:0];
  end

  // table memory write and registered read
  always_ff @(posedge clk) begin
    if (cmd.acc_wr && wr_ok) begin
      mem[wr_addr] <= {in_data.depth_value, in_data.time_value};
    end
    if (rd_en) begin
      rd_word_r <= mem[rd_addr];
      rd_zero_r <= rd_is_origin || !valid_r[rd_addr];
    end
  end

  // per-slot valid bits, unwritten slots read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (cmd.acc_wr && wr_ok) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  assign rd_depth = rd_zero_r ? '0 : rd_word_r[WORD_W-1:TIME_W];
  assign rd_time  = rd_zero_r ? '0 : rd_word_r[TIME_W-1:0];

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_points_r <= NUMP_W'(1);
    end else if (cfg_we) begin
      num_points_r <= cfg_data;
    end
  end

  // segment search state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r     <= '0;
      seg_r   <= '0;
      found_r <= 1'b0;
    end else begin
      if (cmd.acc_q) begin
        k_r     <= IW'(1);
        found_r <= 1'b0;
      end else if (cmd.k_inc) begin
        k_r <= k_r + IW'(1);
      end
      if (cmd.seg_found) begin
        seg_r   <= k_r - IW'(1);
        found_r <= 1'b1;
      end else if (cmd.seg_last) begin
        seg_r <= n_eff - IW'(1);
      end
    end
  end

  // query depth and segment end points
  always_ff @(posedge clk) begin
    if (cmd.acc_q) begin
      q_r <= in_data.depth_value;
    end
    if (cmd.cap_lo) begin
      d0_r <= rd_depth;
      t0_r <= rd_time;
    end
    if (cmd.cap_hi) begin
      d1_r <= rd_depth;
      t1_r <= rd_time;
    end
  end

  // signed differences and exact product
  always_comb begin
    dq = $signed({1'b0, q_r}) - $signed({1'b0, d0_r});
    dt = $signed({1'b0, t1_r}) - $signed({1'b0, t0_r});
    dd = $signed({1'b0, d1_r}) - $signed({1'b0, d0_r});
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_r <= PROD_W'(dq) * PROD_W'(dt);
      den_r  <= dd;
    end
  end

  // magnitudes into the divider, sign kept aside
  assign prod_mag = prod_r[PROD_W-1] ? -prod_r : prod_r;
  assign den_mag  = den_r[DIFF_W-1] ? -den_r : den_r;

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      neg_r <= prod_r[PROD_W-1] ^ den_r[DIFF_W-1];
    end
  end

  pli_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (prod_mag[DIV_W-1:0]),
    .divisor  (den_mag[DEN_W-1:0]),
    .done     (div_done),
    .quotient (div_quo)
  );

  // restore quotient sign, truncation toward zero
  always_ff @(posedge clk) begin
    if (cmd.fix) begin
      quot_r <= neg_r ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
    end
  end

  // add lower time and saturate
  always_comb begin
    sum = $signed({{(SUM_W - TIME_W){1'b0}}, t0_r}) + $signed({quot_r[PROD_W-1], quot_r});
    if (sum[SUM_W-1]) begin
      sat_time = '0;
    end else if (sum[SUM_W-2:TIME_W] != '0) begin
      sat_time = TIME_MAX;
    end else begin
      sat_time = sum[TIME_W-1:0];
    end
  end

  // result selection
  assign zero_width = (d0_r == d1_r);

  always_comb begin
    if (zero_width) begin
      status = RSTAT_ZERO_WIDTH;
    end else if (!found_r && (q_r > d1_r)) begin
      status = RSTAT_EXTRAP;
    end else begin
      status = RSTAT_WITHIN;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_r.result_time   <= zero_width ? t0_r : sat_time;
      out_r.result_status <= status;
    end
  end

  assign out_data = out_r;

  // status to the controller
  always_comb begin
    stat.k_lt_n     = (k_r < n_eff);
    stat.gt         = (rd_depth > q_r);
    stat.zero_width = zero_width;
    stat.div_done   = div_done;
  end

endmodule

// File: src/pli_ctrl.sv
// ----------------------------------------------------------------------------
// pli_ctrl
// Sequencer for table writes, segment search and the interpolation steps.
// ----------------------------------------------------------------------------
module pli_ctrl import pli_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_op,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  pli_stat_t stat,
  output pli_cmd_t  cmd
);

  pli_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free = !out_valid_r || out_ready;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid && in_op == OP_QUERY) state_nxt = S_SRCH_RD;
      end
      S_SRCH_RD:  state_nxt = stat.k_lt_n ? S_SRCH_CMP : S_LO_RD;
      S_SRCH_CMP: state_nxt = stat.gt ? S_LO_RD : S_SRCH_RD;
      S_LO_RD:    state_nxt = S_HI_RD;
      S_HI_RD:    state_nxt = S_HI_WT;
      S_HI_WT:    state_nxt = S_MUL;
      S_MUL:      state_nxt = stat.zero_width ? S_DONE : S_DIV_GO;
      S_DIV_GO:   state_nxt = S_DIV_WAIT;
      S_DIV_WAIT: begin
        if (stat.div_done) state_nxt = S_FIX;
      end
      S_FIX:      state_nxt = S_DONE;
      S_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default:    state_nxt = S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.acc_wr = in_valid && (in_op == OP_WRITE);
        cmd.acc_q  = in_valid && (in_op == OP_QUERY);
      end
      S_SRCH_RD: begin
        if (stat.k_lt_n) begin
          cmd.rd_sel = RD_SRCH;
        end else begin
          cmd.seg_last = 1'b1;
        end
      end
      S_SRCH_CMP: begin
        if (stat.gt) begin
          cmd.seg_found = 1'b1;
        end else begin
          cmd.k_inc = 1'b1;
        end
      end
      S_LO_RD: cmd.rd_sel = RD_LO;
      S_HI_RD: begin
        cmd.rd_sel = RD_HI;
        cmd.cap_lo = 1'b1;
      end
      S_HI_WT:  cmd.cap_hi = 1'b1;
      S_MUL:    cmd.mul = 1'b1;
      S_DIV_GO: cmd.div_start = 1'b1;
      S_FIX:    cmd.fix = 1'b1;
      S_DONE:   cmd.load_out = out_free;
      default: begin
        cmd      = '0;
        in_ready = 1'b0;
      end
    endcase
  end

  // output register valid flag
  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// File: src/piecewise_linear_interpolator_core.sv
// ----------------------------------------------------------------------------
// piecewise_linear_interpolator_core
// Depth-to-time lookup through a loaded breakpoint table with linear
// interpolation, extrapolation past the last point and saturation.
// ----------------------------------------------------------------------------
// A write item stores one breakpoint and gives no result.
// A query scans the table one breakpoint at a time, reading in S_SRCH_RD and
// comparing in S_SRCH_CMP, until a segment's upper depth exceeds the query,
// fetches both segment ends from the single read port of the table,
// multiplies, and divides through a restoring divider that produces one
// quotient bit per cycle. The divider runs 48 steps per query; a zero-width
// segment skips it. A finished query waits in S_DONE while the receiver
// still holds the previous result. One query is in flight at a time; the
// finished result sits in an output register, so the next item is taken
// while it waits. The table reads as all zero after reset with no clearing
// pass. The configuration channel is always ready; the user must write it
// only while the block is idle, and the block itself does not enforce this.
module piecewise_linear_interpolator_core import pli_pkg::*; #(
  parameter int MAX_POINTS = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  pli_stream_if.sink    in_ch,
  pli_stream_if.source  out_ch,
  pli_stream_if.sink    cfg_ch
);

  pli_cmd_t  cmd;
  pli_stat_t stat;
  pli_in_t   in_data;
  pli_out_t  out_data;

  assign in_data      = in_ch.data;
  assign out_ch.data  = out_data;
  assign cfg_ch.ready = 1'b1;

  pli_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_op     (in_data.operation),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  pli_datapath #(
    .MAX_POINTS (MAX_POINTS)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cfg_we   (cfg_ch.valid),
    .cfg_data (NUMP_W'(cfg_ch.data)),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

  // a result is loaded only into a free or draining output register
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_ch.valid || out_ch.ready))
    else $error("result loaded over a pending result");

  // an accepted query blocks further input in the next cycle
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_data.operation == OP_QUERY) |=> !in_ch.ready)
    else $error("input accepted while a query is in progress");

  // only defined status codes leave the block
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_data.result_status == RSTAT_WITHIN ||
                      out_data.result_status == RSTAT_EXTRAP ||
                      out_data.result_status == RSTAT_ZERO_WIDTH))
    else $error("undefined result status");

  // the divider finishes only while a query is in progress
  a_div_busy: assert property (@(posedge clk) disable iff (!rst_n)
    stat.div_done |-> !in_ch.ready)
    else $error("divider finished outside a query");

endmodule
